/* design/bsc_pkg.sv */
`timescale 1ns / 1ps
// Types and constants shared by the barometric compensation pipeline.
package bsc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_AC1    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AC2    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC3    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AC4    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AC5    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AC6    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_B1_B2  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MC_MD  = 3'd7;

   localparam logic [15:0] RST_AC1   = 16'd408;
   localparam logic [15:0] RST_AC2   = 16'hFFB8;
   localparam logic [15:0] RST_AC3   = 16'hC7D1;
   localparam logic [15:0] RST_AC4   = 16'd32741;
   localparam logic [15:0] RST_AC5   = 16'd32757;
   localparam logic [15:0] RST_AC6   = 16'd23153;
   localparam logic [31:0] RST_B1_B2 = 32'd405667844;
   localparam logic [31:0] RST_MC_MD = 32'd3725921076;

   localparam int B6_OFS   = 4000;
   localparam int B4_OFS   = 32768;
   localparam int B7_SCALE = 50000;
   localparam int P_C1     = 3038;
   localparam int P_C2     = -7357;
   localparam int P_C3     = 3791;
   localparam int PRESS_MAX = 262143;

   localparam int TDIV_NW = 27;
   localparam int TDIV_DW = 18;
   localparam int PDIV_NW = 32;
   localparam int PDIV_DW = 32;

   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic [15:0]        ac4;
      logic [15:0]        ac5;
      logic [15:0]        ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
   } cal_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic signed [29:0] b6;
      logic               dz;
      logic [23:0]        up;
      logic [1:0]         oss;
   } tmp_item_type;

   typedef struct packed {
      logic signed [15:0] temp;
      logic [17:0]        press;
      logic               status;
   } rsp_type;

endpackage

/* design/bsc_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per stage.
module bsc_div #(
   parameter int NW = 32,
   parameter int DW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          valid_ff [NW];
   logic [DW-1:0] rem_ff   [NW];
   logic [NW-1:0] nq_ff    [NW];
   logic [DW-1:0] den_ff   [NW];
   logic [SW-1:0] side_ff  [NW];

   for (genvar g = 0; g < NW; g++) begin : g_step
      logic          valid_src;
      logic [DW-1:0] rem_src;
      logic [NW-1:0] nq_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          fits;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      if (g == 0) begin : g_head
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign nq_src    = in_num;
         assign den_src   = in_den;
         assign side_src  = in_side;
      end else begin : g_body
         assign valid_src = valid_ff[g-1];
         assign rem_src   = rem_ff[g-1];
         assign nq_src    = nq_ff[g-1];
         assign den_src   = den_ff[g-1];
         assign side_src  = side_ff[g-1];
      end

      always_comb begin
         trial  = {rem_src, nq_src[NW-1]};
         diff   = trial - {1'b0, den_src};
         fits   = trial >= {1'b0, den_src};
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         nq_in  = {nq_src[NW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            nq_ff[g]   <= nq_in;
            den_ff[g]  <= den_src;
            side_ff[g] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_quo   = nq_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

/* design/bsc_temp.sv */
`timescale 1ns / 1ps
// Temperature compensation stages: B5, temperature and B6.
module bsc_temp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [15:0]           ut_word,
   input  logic [23:0]           raw_press,
   input  logic [1:0]            oss_mode,
   input  bsc_pkg::cal_type      cal,
   output logic                  out_valid,
   output bsc_pkg::tmp_item_type out_item
);

   localparam int SIDE_W = 47;

   // stage 1
   logic signed [16:0] diff1;
   logic signed [16:0] ac5s;
   logic signed [33:0] prod1_in, prod1_ff;
   logic [23:0]        up1_in, up1_ff;
   logic [1:0]         oss1_ff;
   logic               v1_ff;

   // stage 2
   logic signed [18:0] x1_in, x1_ff;
   logic signed [18:0] div_in, div_ff;
   logic [23:0]        up2_ff;
   logic [1:0]         oss2_ff;
   logic               v2_ff;

   // divider feed
   logic [18:0]                  dmag;
   logic [15:0]                  mcabs;
   logic [bsc_pkg::TDIV_NW-1:0]  dnum;
   logic [bsc_pkg::TDIV_DW-1:0]  dden;
   logic [SIDE_W-1:0]            dside;
   logic                         dq_valid;
   logic [bsc_pkg::TDIV_NW-1:0]  dq;
   logic [SIDE_W-1:0]            dq_side;

   // after divider
   logic               q_neg;
   logic               q_dz;
   logic signed [18:0] q_x1;
   logic [23:0]        q_up;
   logic [1:0]         q_oss;
   logic signed [27:0] x2;
   logic signed [28:0] b5_in, b5_ff;
   logic               dz3_ff;
   logic [23:0]        up3_ff;
   logic [1:0]         oss3_ff;
   logic               v3_ff;

   logic signed [29:0] tsum;
   logic signed [29:0] tval;
   logic signed [15:0] tsat;
   bsc_pkg::tmp_item_type item_in, item_ff;
   logic               v4_ff;

   always_comb begin
      diff1    = $signed({1'b0, ut_word}) - $signed({1'b0, cal.ac6});
      ac5s     = $signed({1'b0, cal.ac5});
      prod1_in = diff1 * ac5s;
      up1_in   = raw_press >> (4'd8 - {2'b00, oss_mode});
   end

   always_comb begin
      x1_in  = 19'(prod1_ff >>> 15);
      div_in = x1_in + 19'(cal.md);
   end

   always_comb begin
      dmag  = div_ff[18] ? 19'(-div_ff) : div_ff;
      mcabs = cal.mc[15] ? 16'(-cal.mc) : cal.mc;
      dnum  = {mcabs, 11'b0};
      dden  = dmag[bsc_pkg::TDIV_DW-1:0];
      dside = {cal.mc[15] ^ div_ff[18], div_ff == 19'sd0, x1_ff, up2_ff, oss2_ff};
   end

   bsc_div #(
      .NW(bsc_pkg::TDIV_NW),
      .DW(bsc_pkg::TDIV_DW),
      .SW(SIDE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v2_ff),
      .in_num   (dnum),
      .in_den   (dden),
      .in_side  (dside),
      .out_valid(dq_valid),
      .out_quo  (dq),
      .out_side (dq_side)
   );

   always_comb begin
      {q_neg, q_dz, q_x1, q_up, q_oss} = dq_side;
      x2    = q_neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
      b5_in = 29'(q_x1) + 29'(x2);
   end

   always_comb begin
      tsum = 30'(b5_ff) + 30'sd8;
      tval = tsum >>> 4;
      if (tval > 30'sd32767) begin
         tsat = 16'sh7FFF;
      end else if (tval < -30'sd32768) begin
         tsat = -16'sh8000;
      end else begin
         tsat = tval[15:0];
      end
      item_in.temp = tsat;
      item_in.b6   = 30'(b5_ff) - 30'(bsc_pkg::B6_OFS);
      item_in.dz   = dz3_ff;
      item_in.up   = up3_ff;
      item_in.oss  = oss3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= dq_valid;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= prod1_in;
         up1_ff   <= up1_in;
         oss1_ff  <= oss_mode;
         x1_ff    <= x1_in;
         div_ff   <= div_in;
         up2_ff   <= up1_ff;
         oss2_ff  <= oss1_ff;
         b5_ff    <= b5_in;
         dz3_ff   <= q_dz;
         up3_ff   <= q_up;
         oss3_ff  <= q_oss;
         item_ff  <= item_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_item  = item_ff;

endmodule

/* design/bsc_press.sv */
`timescale 1ns / 1ps
// Pressure compensation stages: B3, B4, B7, the pressure divide and the final correction.
module bsc_press (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  bsc_pkg::tmp_item_type in_item,
   input  bsc_pkg::cal_type      cal,
   output logic                  out_valid,
   output bsc_pkg::rsp_type      out_res
);

   localparam int SIDE_W = 19;

   logic [6:0] v_ff;

   // P1
   logic [29:0]        mag_full;
   logic [28:0]        mag;
   logic [57:0]        sq_in, sq_ff;
   logic signed [45:0] ac2b6_in, ac2b6_ff, ac3b6_in, ac3b6_ff;
   // P2
   logic [45:0]        b6sq;
   logic signed [23:0] hs, ls;
   logic signed [39:0] b2h_in, b2h_ff, b2l_in, b2l_ff, b1h_in, b1h_ff, b1l_in, b1l_ff;
   logic signed [34:0] x2a_in, x2a_ff, x2a3_ff;
   logic signed [32:0] x1c_in, x1c_ff, x1c3_ff;
   // P3
   logic signed [63:0] b2sq_in, b2sq_ff, b1sq_in, b1sq_ff;
   // P4
   logic signed [63:0] x3a_in, x3a_ff, x3s_in, x3s_ff;
   // P5
   logic signed [63:0] y5, b3w, x3cw;
   logic [31:0]        b3_in, b3_ff, x3c_in, x3c_ff;
   // P6
   logic [31:0]        um_in, um_ff, u6;
   logic [47:0]        b4p_in, b4p_ff;
   // P7
   logic [15:0]        scale;
   logic [47:0]        b7w;
   logic [31:0]        b7_in, b7_ff, b4_in, b4_ff;

   // payload carried along P1..P7
   logic signed [15:0] temp_ff [7];
   logic               dz_ff   [7];
   logic [23:0]        up_ff   [6];
   logic [1:0]         oss_ff  [6];

   // divider
   logic                         big;
   logic [bsc_pkg::PDIV_NW-1:0]  dnum;
   logic [SIDE_W-1:0]            dside;
   logic                         dq_valid;
   logic [bsc_pkg::PDIV_NW-1:0]  dq;
   logic [SIDE_W-1:0]            dq_side;
   logic signed [15:0]           q_temp;
   logic                         q_dz, q_bz, q_big;

   // Q stages
   logic [4:0]         vq_ff;
   logic [32:0]        p_in, p_ff [4];
   logic signed [15:0] qtemp_ff [4];
   logic               qdz_ff [4];
   logic               qbz_ff [4];
   logic [24:0]        x1q;
   logic [49:0]        x1sq_in, x1sq_ff;
   logic signed [13:0] c2;
   logic signed [47:0] x2q_in, x2q_ff;
   logic [61:0]        x1m_prod;
   logic [45:0]        x1m_in, x1m_ff;
   logic signed [31:0] x2s_in, x2s_ff;
   logic signed [47:0] ssum;
   logic signed [47:0] s_in, s_ff;
   logic signed [47:0] pf;
   bsc_pkg::rsp_type   res_in, res_ff;

   always_comb begin
      mag_full = in_item.b6[29] ? 30'(-in_item.b6) : in_item.b6;
      mag      = mag_full[28:0];
      sq_in    = 58'(mag) * 58'(mag);
      ac2b6_in = cal.ac2 * 46'(in_item.b6);
      ac3b6_in = cal.ac3 * 46'(in_item.b6);
   end

   always_comb begin
      b6sq   = 46'(sq_ff >> 12);
      hs     = $signed({1'b0, b6sq[45:23]});
      ls     = $signed({1'b0, b6sq[22:0]});
      b2h_in = cal.b2 * hs;
      b2l_in = cal.b2 * ls;
      b1h_in = cal.b1 * hs;
      b1l_in = cal.b1 * ls;
      x2a_in = 35'(ac2b6_ff >>> 11);
      x1c_in = 33'(ac3b6_ff >>> 13);
   end

   always_comb begin
      b2sq_in = (64'(b2h_ff) <<< 23) + 64'(b2l_ff);
      b1sq_in = (64'(b1h_ff) <<< 23) + 64'(b1l_ff);
   end

   always_comb begin
      x3a_in = (b2sq_ff >>> 11) + 64'(x2a3_ff);
      x3s_in = 64'(x1c3_ff) + (b1sq_ff >>> 16);
   end

   always_comb begin
      y5     = ((64'(cal.ac1) <<< 2) + x3a_ff) <<< oss_ff[3];
      b3w    = (y5 + 64'sd2) >>> 2;
      x3cw   = (x3s_ff + 64'sd2) >>> 2;
      b3_in  = b3w[31:0];
      x3c_in = x3cw[31:0];
   end

   always_comb begin
      um_in  = 32'(up_ff[4]) - b3_ff;
      u6     = x3c_ff + 32'(bsc_pkg::B4_OFS);
      b4p_in = 48'(cal.ac4) * 48'(u6);
   end

   always_comb begin
      scale = 16'(bsc_pkg::B7_SCALE >> oss_ff[5]);
      b7w   = 48'(um_ff) * 48'(scale);
      b7_in = b7w[31:0];
      b4_in = b4p_ff[46:15];
   end

   always_comb begin
      big   = b7_ff[31];
      dnum  = big ? b7_ff : {b7_ff[30:0], 1'b0};
      dside = {temp_ff[6], dz_ff[6], b4_ff == 32'd0, big};
   end

   bsc_div #(
      .NW(bsc_pkg::PDIV_NW),
      .DW(bsc_pkg::PDIV_DW),
      .SW(SIDE_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v_ff[6]),
      .in_num   (dnum),
      .in_den   (b4_ff),
      .in_side  (dside),
      .out_valid(dq_valid),
      .out_quo  (dq),
      .out_side (dq_side)
   );

   always_comb begin
      {q_temp, q_dz, q_bz, q_big} = dq_side;
      p_in = q_big ? {dq, 1'b0} : {1'b0, dq};
   end

   always_comb begin
      x1q     = p_ff[0][32:8];
      x1sq_in = 50'(x1q) * 50'(x1q);
      c2      = 14'(bsc_pkg::P_C2);
      x2q_in  = c2 * $signed({1'b0, p_ff[0]});
   end

   always_comb begin
      x1m_prod = 62'(x1sq_ff) * 62'(bsc_pkg::P_C1);
      x1m_in   = x1m_prod[61:16];
      x2s_in   = 32'(x2q_ff >>> 16);
   end

   always_comb begin
      ssum = $signed({2'b00, x1m_ff}) + 48'(x2s_ff) + 48'(bsc_pkg::P_C3);
      s_in = ssum >>> 4;
   end

   always_comb begin
      pf = $signed({15'b0, p_ff[3]}) + s_ff;
      if (qdz_ff[3] || qbz_ff[3]) begin
         res_in.press = '0;
      end else if (pf < 48'sd0) begin
         res_in.press = '0;
      end else if (pf > 48'(bsc_pkg::PRESS_MAX)) begin
         res_in.press = 18'(bsc_pkg::PRESS_MAX);
      end else begin
         res_in.press = pf[17:0];
      end
      res_in.temp   = qdz_ff[3] ? 16'sd0 : qtemp_ff[3];
      res_in.status = qdz_ff[3] | qbz_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= '0;
         vq_ff <= '0;
      end else if (en) begin
         v_ff  <= {v_ff[5:0], in_valid};
         vq_ff <= {vq_ff[3:0], dq_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         ac2b6_ff <= ac2b6_in;
         ac3b6_ff <= ac3b6_in;
         b2h_ff   <= b2h_in;
         b2l_ff   <= b2l_in;
         b1h_ff   <= b1h_in;
         b1l_ff   <= b1l_in;
         x2a_ff   <= x2a_in;
         x1c_ff   <= x1c_in;
         b2sq_ff  <= b2sq_in;
         b1sq_ff  <= b1sq_in;
         x2a3_ff  <= x2a_ff;
         x1c3_ff  <= x1c_ff;
         x3a_ff   <= x3a_in;
         x3s_ff   <= x3s_in;
         b3_ff    <= b3_in;
         x3c_ff   <= x3c_in;
         um_ff    <= um_in;
         b4p_ff   <= b4p_in;
         b7_ff    <= b7_in;
         b4_ff    <= b4_in;

         temp_ff[0] <= in_item.temp;
         dz_ff[0]   <= in_item.dz;
         up_ff[0]   <= in_item.up;
         oss_ff[0]  <= in_item.oss;
         for (int i = 1; i < 7; i++) begin
            temp_ff[i] <= temp_ff[i-1];
            dz_ff[i]   <= dz_ff[i-1];
         end
         for (int i = 1; i < 6; i++) begin
            up_ff[i]  <= up_ff[i-1];
            oss_ff[i] <= oss_ff[i-1];
         end

         p_ff[0]     <= p_in;
         qtemp_ff[0] <= q_temp;
         qdz_ff[0]   <= q_dz;
         qbz_ff[0]   <= q_bz;
         for (int i = 1; i < 4; i++) begin
            p_ff[i]     <= p_ff[i-1];
            qtemp_ff[i] <= qtemp_ff[i-1];
            qdz_ff[i]   <= qdz_ff[i-1];
            qbz_ff[i]   <= qbz_ff[i-1];
         end

         x1sq_ff <= x1sq_in;
         x2q_ff  <= x2q_in;
         x1m_ff  <= x1m_in;
         x2s_ff  <= x2s_in;
         s_ff    <= s_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid = vq_ff[4];
   assign out_res   = res_ff;

endmodule

/* design/baro_sensor_compensation.sv */
`timescale 1ns / 1ps
// Top level: calibration registers, compensation pipeline and output queue.
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/stall    ut_word, raw_press, oss_mode
//   rsp_        out        rsp_valid/stall    temp_tenths_c, press_pa, status
//   csr_        in         csr_wr_en          csr_index, csr_wdata
//
// One request per cycle while req_stall is low; rsp_valid rises once the result has passed
// the 27-stage and 32-stage pipelined dividers plus the multiply stages around them.
// A two-entry output queue absorbs rsp_stall; the pipeline holds only when it is full.
// Synchronous reset clears valid bits, queue pointers and calibration to defaults.
module baro_sensor_compensation (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [15:0]                    req_ut_word,
   input  logic [23:0]                    req_raw_press,
   input  logic [1:0]                     req_oss_mode,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [15:0]             rsp_temp_tenths_c,
   output logic [17:0]                    rsp_press_pa,
   output logic                           rsp_status,
   input  logic                           csr_wr_en,
   input  logic [bsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   bsc_pkg::cal_type      cal_ff;
   logic                  en;
   logic                  tmp_valid;
   bsc_pkg::tmp_item_type tmp_item;
   logic                  press_valid;
   bsc_pkg::rsp_type      press_res;

   bsc_pkg::rsp_type slot_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push, pop;
   bsc_pkg::rsp_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.ac1 <= bsc_pkg::RST_AC1;
         cal_ff.ac2 <= bsc_pkg::RST_AC2;
         cal_ff.ac3 <= bsc_pkg::RST_AC3;
         cal_ff.ac4 <= bsc_pkg::RST_AC4;
         cal_ff.ac5 <= bsc_pkg::RST_AC5;
         cal_ff.ac6 <= bsc_pkg::RST_AC6;
         cal_ff.b1  <= bsc_pkg::RST_B1_B2[31:16];
         cal_ff.b2  <= bsc_pkg::RST_B1_B2[15:0];
         cal_ff.mc  <= bsc_pkg::RST_MC_MD[31:16];
         cal_ff.md  <= bsc_pkg::RST_MC_MD[15:0];
      end else if (csr_wr_en) begin
         unique case (csr_index)
            bsc_pkg::CSR_AC1:   cal_ff.ac1 <= csr_wdata[15:0];
            bsc_pkg::CSR_AC2:   cal_ff.ac2 <= csr_wdata[15:0];
            bsc_pkg::CSR_AC3:   cal_ff.ac3 <= csr_wdata[15:0];
            bsc_pkg::CSR_AC4:   cal_ff.ac4 <= csr_wdata[15:0];
            bsc_pkg::CSR_AC5:   cal_ff.ac5 <= csr_wdata[15:0];
            bsc_pkg::CSR_AC6:   cal_ff.ac6 <= csr_wdata[15:0];
            bsc_pkg::CSR_B1_B2: begin
               cal_ff.b1 <= csr_wdata[31:16];
               cal_ff.b2 <= csr_wdata[15:0];
            end
            bsc_pkg::CSR_MC_MD: begin
               cal_ff.mc <= csr_wdata[31:16];
               cal_ff.md <= csr_wdata[15:0];
            end
         endcase
      end
   end

   assign en        = count_ff != 2'd2;
   assign req_stall = !en;

   bsc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .ut_word  (req_ut_word),
      .raw_press(req_raw_press),
      .oss_mode (req_oss_mode),
      .cal      (cal_ff),
      .out_valid(tmp_valid),
      .out_item (tmp_item)
   );

   bsc_press u_press (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (tmp_valid),
      .in_item  (tmp_item),
      .cal      (cal_ff),
      .out_valid(press_valid),
      .out_res  (press_res)
   );

   assign push = en && press_valid;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= press_res;
      end
   end

   assign head              = slot_ff[rd_ptr_ff];
   assign rsp_valid         = count_ff != 2'd0;
   assign rsp_temp_tenths_c = head.temp;
   assign rsp_press_pa      = head.press;
   assign rsp_status        = head.status;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("output queue count out of range");

   a_error_zero_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_press_pa == 18'd0))
      else $error("error result carries nonzero pressure");

   a_rise_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(push))
      else $error("result appeared without a push");

endmodule
